[src/bmf_pkg.sv]
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared types and constants of the bounded message FIFO.
// ----------------------------------------------------------------------------
package bmf_pkg;

   // Default sizes of the message store.
   localparam int DEF_MAX_MSGS      = 16;
   localparam int DEF_MAX_MSG_BYTES = 64;

   // Field widths of the request and response words.
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 7;
   localparam int STATUS_W = 3;

   // Reset value of the message length limit register.
   localparam logic [LEN_W-1:0] LEN_LIMIT_RST = 7'd64;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 3'd0,
      ST_FULL  = 3'd1,
      ST_LONG  = 3'd2,
      ST_EMPTY = 3'd3,
      ST_SMALL = 3'd4
   } status_type;

   // One response word as produced by a controller.
   typedef struct packed {
      logic              valid;
      status_type        status;
      logic [LEN_W-1:0]  msg_length;
      logic              final_res;
      logic              byte_sel;
   } rsp_type;

endpackage

[src/bmf_ram.sv]
// ----------------------------------------------------------------------------
// bmf_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module bmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/bmf_wr_ctrl.sv]
// ----------------------------------------------------------------------------
// bmf_wr_ctrl
// Write side: stores message bytes at the tail slot and commits or rejects
// the message when its last byte arrives.
// ----------------------------------------------------------------------------
module bmf_wr_ctrl #(
   parameter int MAX_MSGS      = bmf_pkg::DEF_MAX_MSGS,
   parameter int MAX_MSG_BYTES = bmf_pkg::DEF_MAX_MSG_BYTES,
   localparam int SLOT_W = (MAX_MSGS > 1) ? $clog2(MAX_MSGS) : 1,
   localparam int BIDX_W = (MAX_MSG_BYTES > 1) ? $clog2(MAX_MSG_BYTES) : 1,
   localparam int BA_W   = (MAX_MSGS * MAX_MSG_BYTES > 1) ?
                           $clog2(MAX_MSGS * MAX_MSG_BYTES) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [bmf_pkg::BYTE_W-1:0]  data_byte,
   input  logic                        end_of_msg,
   input  logic [bmf_pkg::LEN_W-1:0]   len_limit,
   input  logic                        queue_full,
   output logic                        byte_we,
   output logic [BA_W-1:0]             byte_waddr,
   output logic [bmf_pkg::BYTE_W-1:0]  byte_wdata,
   output logic                        len_we,
   output logic [SLOT_W-1:0]           len_waddr,
   output logic [bmf_pkg::LEN_W-1:0]   len_wdata,
   output logic                        commit,
   output bmf_pkg::rsp_type            rsp
);

   typedef enum logic [1:0] {
      REJ_NONE = 2'd0,
      REJ_FULL = 2'd1,
      REJ_LONG = 2'd2
   } rej_type;

   logic [SLOT_W-1:0]          tail_ff, tail_in;
   logic [bmf_pkg::LEN_W-1:0]  wbc_ff, wbc_in;
   rej_type                    rej_ff, rej_in;
   bmf_pkg::rsp_type           rsp_ff, rsp_in;

   logic                       store;
   rej_type                    rej_new;
   logic [bmf_pkg::LEN_W-1:0]  wbc_new;

   // Outcome of the incoming byte for the open message.
   always_comb begin
      rej_new = rej_ff;
      wbc_new = wbc_ff;
      store   = 1'b0;
      if (rej_ff == REJ_NONE) begin
         if (queue_full) begin
            rej_new = REJ_FULL;
         end else if (wbc_ff >= bmf_pkg::LEN_W'(MAX_MSG_BYTES)) begin
            rej_new = REJ_LONG;
         end else begin
            store   = 1'b1;
            wbc_new = wbc_ff + 1'b1;
         end
      end
   end

   // Commit or rejection at the close of a message.
   always_comb begin
      tail_in = tail_ff;
      wbc_in  = wbc_ff;
      rej_in  = rej_ff;
      rsp_in  = '0;
      commit  = 1'b0;
      if (accept) begin
         wbc_in = wbc_new;
         rej_in = rej_new;
         if (end_of_msg) begin
            wbc_in           = '0;
            rej_in           = REJ_NONE;
            rsp_in.valid     = 1'b1;
            rsp_in.final_res = 1'b1;
            if ((rej_new == REJ_FULL) || queue_full) begin
               rsp_in.status = bmf_pkg::ST_FULL;
            end else if ((rej_new == REJ_LONG) || (wbc_new > len_limit)) begin
               rsp_in.status = bmf_pkg::ST_LONG;
            end else begin
               rsp_in.status     = bmf_pkg::ST_OK;
               rsp_in.msg_length = wbc_new;
               commit            = 1'b1;
               tail_in = (tail_ff == SLOT_W'(MAX_MSGS - 1)) ? '0 : tail_ff + 1'b1;
            end
         end
      end
   end

   // Memory write ports.
   assign byte_we    = accept && store;
   assign byte_waddr = BA_W'(tail_ff) * BA_W'(MAX_MSG_BYTES) + BA_W'(wbc_ff[BIDX_W-1:0]);
   assign byte_wdata = data_byte;
   assign len_we     = commit;
   assign len_waddr  = tail_ff;
   assign len_wdata  = wbc_new;

   // Write-side state.
   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff <= '0;
         wbc_ff  <= '0;
         rej_ff  <= REJ_NONE;
         rsp_ff  <= '0;
      end else begin
         tail_ff <= tail_in;
         wbc_ff  <= wbc_in;
         rej_ff  <= rej_in;
         rsp_ff  <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

[src/bmf_rd_ctrl.sv]
// ----------------------------------------------------------------------------
// bmf_rd_ctrl
// Read side: checks the head message against the reader's capacity and
// streams its bytes from the byte store, one word per cycle.
// ----------------------------------------------------------------------------
module bmf_rd_ctrl #(
   parameter int MAX_MSGS      = bmf_pkg::DEF_MAX_MSGS,
   parameter int MAX_MSG_BYTES = bmf_pkg::DEF_MAX_MSG_BYTES,
   localparam int SLOT_W = (MAX_MSGS > 1) ? $clog2(MAX_MSGS) : 1,
   localparam int BIDX_W = (MAX_MSG_BYTES > 1) ? $clog2(MAX_MSG_BYTES) : 1,
   localparam int BA_W   = (MAX_MSGS * MAX_MSG_BYTES > 1) ?
                           $clog2(MAX_MSGS * MAX_MSG_BYTES) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [bmf_pkg::LEN_W-1:0]   capacity,
   input  logic                        queue_empty,
   output logic                        busy,
   output logic                        len_re,
   output logic [SLOT_W-1:0]           len_raddr,
   input  logic [bmf_pkg::LEN_W-1:0]   len_rdata,
   output logic                        byte_re,
   output logic [BA_W-1:0]             byte_raddr,
   output logic                        pop,
   output bmf_pkg::rsp_type            rsp
);

   typedef enum logic [2:0] {
      RD_IDLE   = 3'b001,
      RD_LEN    = 3'b010,
      RD_STREAM = 3'b100
   } rd_state_type;

   rd_state_type               state_ff, state_in;
   logic [SLOT_W-1:0]          head_ff, head_in;
   logic [BIDX_W-1:0]          idx_ff, idx_in;
   logic [bmf_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [bmf_pkg::LEN_W-1:0]  cap_ff, cap_in;
   bmf_pkg::rsp_type           rsp_ff, rsp_in;
   logic                       last_byte;

   assign last_byte = (bmf_pkg::LEN_W'(idx_ff) + 1'b1) == len_ff;

   // Read sequencer.
   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      idx_in   = idx_ff;
      len_in   = len_ff;
      cap_in   = cap_ff;
      rsp_in   = '0;
      len_re   = 1'b0;
      byte_re  = 1'b0;
      pop      = 1'b0;
      unique case (state_ff)
         RD_IDLE: begin
            if (accept) begin
               if (queue_empty) begin
                  rsp_in.valid     = 1'b1;
                  rsp_in.status    = bmf_pkg::ST_EMPTY;
                  rsp_in.final_res = 1'b1;
               end else begin
                  len_re   = 1'b1;
                  cap_in   = capacity;
                  state_in = RD_LEN;
               end
            end
         end
         RD_LEN: begin
            if (len_rdata > cap_ff) begin
               rsp_in.valid     = 1'b1;
               rsp_in.status    = bmf_pkg::ST_SMALL;
               rsp_in.final_res = 1'b1;
               state_in         = RD_IDLE;
            end else begin
               len_in   = len_rdata;
               idx_in   = '0;
               state_in = RD_STREAM;
            end
         end
         RD_STREAM: begin
            byte_re           = 1'b1;
            rsp_in.valid      = 1'b1;
            rsp_in.status     = bmf_pkg::ST_OK;
            rsp_in.msg_length = len_ff;
            rsp_in.final_res  = last_byte;
            rsp_in.byte_sel   = 1'b1;
            if (last_byte) begin
               pop      = 1'b1;
               head_in  = (head_ff == SLOT_W'(MAX_MSGS - 1)) ? '0 : head_ff + 1'b1;
               state_in = RD_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = RD_IDLE;
         end
      endcase
   end

   assign len_raddr  = head_ff;
   assign byte_raddr = BA_W'(head_ff) * BA_W'(MAX_MSG_BYTES) + BA_W'(idx_ff);
   assign busy       = (state_ff != RD_IDLE);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RD_IDLE;
         head_ff  <= '0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         rsp_ff   <= rsp_in;
      end
   end

   // Working registers of the current read.
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      len_ff <= len_in;
      cap_ff <= cap_in;
   end

   assign rsp = rsp_ff;

endmodule

[src/bounded_message_fifo.sv]
// ----------------------------------------------------------------------------
// bounded_message_fifo
// FIFO of whole messages held in a byte store and a length table, committed
// or rejected as a unit.
// ----------------------------------------------------------------------------
// Usage:
// A request word is taken at a clock edge where start is high and busy low.
// A write word (req_type 0) carries one byte; the word with req_end_of_msg
// set closes the message, and one status word follows in the next cycle.
// Non-final write bytes give no response and do not raise busy.
// A read word (req_type 1) asks for the head message. If the queue is empty
// the status word follows in the next cycle; if the message exceeds
// req_capacity the status word follows the RD_LEN state and busy is high
// for one cycle. Otherwise the bytes stream out one per cycle after the
// length is read in RD_LEN, the final one with rsp_final_res set.
// A read keeps busy high through the RD_LEN and RD_STREAM states; the next
// request may be taken in the cycle its last byte is shown.
// Every response word stands for exactly one cycle, marked by rsp_strobe;
// the receiver cannot stall the block.
// Reset empties the queue, drops any open message and sets the maximum
// message size to 64; the memories need no clearing pass.
// ----------------------------------------------------------------------------
module bounded_message_fifo #(
   parameter int MAX_MSGS      = bmf_pkg::DEF_MAX_MSGS,
   parameter int MAX_MSG_BYTES = bmf_pkg::DEF_MAX_MSG_BYTES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic [bmf_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic                          req_end_of_msg,
   input  logic [bmf_pkg::LEN_W-1:0]     req_capacity,
   output logic                          rsp_strobe,
   output logic [bmf_pkg::STATUS_W-1:0]  rsp_status,
   output logic [bmf_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic [bmf_pkg::LEN_W-1:0]     rsp_msg_length,
   output logic                          rsp_final_res,
   input  logic                          csr_wr_en,
   input  logic [bmf_pkg::LEN_W-1:0]     csr_wr_data
);

   localparam int SLOT_W = (MAX_MSGS > 1) ? $clog2(MAX_MSGS) : 1;
   localparam int CNT_W  = $clog2(MAX_MSGS + 1);
   localparam int BDEPTH = MAX_MSGS * MAX_MSG_BYTES;
   localparam int BA_W   = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;

   logic [bmf_pkg::LEN_W-1:0]  max_size_ff;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       queue_full, queue_empty;
   logic                       wr_accept, rd_accept;

   logic                       byte_we, byte_re;
   logic [BA_W-1:0]            byte_waddr, byte_raddr;
   logic [bmf_pkg::BYTE_W-1:0] byte_wdata, byte_rdata;
   logic                       len_we, len_re;
   logic [SLOT_W-1:0]          len_waddr, len_raddr;
   logic [bmf_pkg::LEN_W-1:0]  len_wdata, len_rdata;
   logic                       commit, pop;
   bmf_pkg::rsp_type           wr_rsp, rd_rsp, rsp;

   // Request decode.
   assign wr_accept   = start && !busy && !req_type;
   assign rd_accept   = start && !busy && req_type;
   assign queue_full  = (count_ff == CNT_W'(MAX_MSGS));
   assign queue_empty = (count_ff == '0);

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff <= bmf_pkg::LEN_LIMIT_RST;
      end else if (csr_wr_en) begin
         max_size_ff <= csr_wr_data;
      end
   end

   // Message count, raised on commit and lowered once a message is read out.
   always_comb begin
      count_in = count_ff;
      if (commit && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !commit) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Byte store.
   bmf_ram #(
      .WIDTH (bmf_pkg::BYTE_W),
      .DEPTH (BDEPTH)
   ) u_byte_store (
      .clock   (clock),
      .wr_en   (byte_we),
      .wr_addr (byte_waddr),
      .wr_data (byte_wdata),
      .rd_en   (byte_re),
      .rd_addr (byte_raddr),
      .rd_data (byte_rdata)
   );

   // Length table.
   bmf_ram #(
      .WIDTH (bmf_pkg::LEN_W),
      .DEPTH (MAX_MSGS)
   ) u_length_table (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (len_waddr),
      .wr_data (len_wdata),
      .rd_en   (len_re),
      .rd_addr (len_raddr),
      .rd_data (len_rdata)
   );

   // Write side.
   bmf_wr_ctrl #(
      .MAX_MSGS      (MAX_MSGS),
      .MAX_MSG_BYTES (MAX_MSG_BYTES)
   ) u_wr_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (wr_accept),
      .data_byte    (req_data_byte),
      .end_of_msg   (req_end_of_msg),
      .len_limit    (max_size_ff),
      .queue_full   (queue_full),
      .byte_we      (byte_we),
      .byte_waddr   (byte_waddr),
      .byte_wdata   (byte_wdata),
      .len_we       (len_we),
      .len_waddr    (len_waddr),
      .len_wdata    (len_wdata),
      .commit       (commit),
      .rsp          (wr_rsp)
   );

   // Read side.
   bmf_rd_ctrl #(
      .MAX_MSGS      (MAX_MSGS),
      .MAX_MSG_BYTES (MAX_MSG_BYTES)
   ) u_rd_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (rd_accept),
      .capacity    (req_capacity),
      .queue_empty (queue_empty),
      .busy        (busy),
      .len_re      (len_re),
      .len_raddr   (len_raddr),
      .len_rdata   (len_rdata),
      .byte_re     (byte_re),
      .byte_raddr  (byte_raddr),
      .pop         (pop),
      .rsp         (rd_rsp)
   );

   // Response merge: the two sides never present a word in the same cycle.
   assign rsp            = wr_rsp.valid ? wr_rsp : rd_rsp;
   assign rsp_strobe     = rsp.valid;
   assign rsp_status     = rsp.status;
   assign rsp_out_byte   = rsp.byte_sel ? byte_rdata : '0;
   assign rsp_msg_length = rsp.msg_length;
   assign rsp_final_res  = rsp.final_res;

endmodule

[bench/tb_bounded_message_fifo.sv]
// ----------------------------------------------------------------------------
// tb_bounded_message_fifo
// Self-checking bench for the bounded message FIFO. A short table of request
// words covers the empty queue, every read outcome, the size limit at its
// extremes and a full queue. Random message traffic with random gaps and
// random limits follows. Every response word is checked against the word
// expected from the table or from a mirror of the message queue in the bench.
// ----------------------------------------------------------------------------
module tb_bounded_message_fifo;

   localparam int   SLOTS      = bmf_pkg::DEF_MAX_MSGS;
   localparam int   SLOT_BYTES = bmf_pkg::DEF_MAX_MSG_BYTES;
   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   // Why the open message will be dropped at its close.
   typedef enum logic [1:0] {REJ_NONE, REJ_FULL, REJ_LONG} reject_type;

   // Kinds of row in the directed table.
   typedef enum logic [1:0] {ROW_WRITE, ROW_READ, ROW_CSR} row_kind_type;

   typedef struct packed {
      bmf_pkg::status_type        status;
      logic [bmf_pkg::BYTE_W-1:0] out_byte;
      logic [bmf_pkg::LEN_W-1:0]  msg_length;
      logic                       final_res;
   } rsp_word_type;

   // Value is the byte of a write, the capacity of a read or the register
   // value of a register write.
   typedef struct packed {
      row_kind_type               kind;
      logic [7:0]                 value;
      logic                       eom;
      logic [4:0]                 reps;
      logic                       typed;
      bmf_pkg::status_type        status;
      logic [bmf_pkg::LEN_W-1:0]  msg_length;
   } plan_row_type;

   logic                         clock          = 1'b0;
   logic                         reset          = 1'b1;
   logic                         start          = 1'b0;
   logic                         busy;
   logic                         req_type       = 1'b0;
   logic [bmf_pkg::BYTE_W-1:0]   req_data_byte  = '0;
   logic                         req_end_of_msg = 1'b0;
   logic [bmf_pkg::LEN_W-1:0]    req_capacity   = '0;
   logic                         rsp_strobe;
   logic [bmf_pkg::STATUS_W-1:0] rsp_status;
   logic [bmf_pkg::BYTE_W-1:0]   rsp_out_byte;
   logic [bmf_pkg::LEN_W-1:0]    rsp_msg_length;
   logic                         rsp_final_res;
   logic                         csr_wr_en      = 1'b0;
   logic [bmf_pkg::LEN_W-1:0]    csr_wr_data    = '0;

   // Mirror of the message queue.
   logic [bmf_pkg::BYTE_W-1:0] byte_mirror [SLOTS][SLOT_BYTES];
   logic [bmf_pkg::LEN_W-1:0]  length_mirror [SLOTS];
   logic [$clog2(SLOTS)-1:0]   head_slot   = '0;
   logic [$clog2(SLOTS)-1:0]   tail_slot   = '0;
   logic [$clog2(SLOTS):0]     queued_msgs = '0;
   logic [bmf_pkg::LEN_W-1:0]  open_bytes  = '0;
   reject_type                 open_reject = REJ_NONE;
   logic [bmf_pkg::LEN_W-1:0]  size_limit  = bmf_pkg::LEN_LIMIT_RST;

   rsp_word_type step_words [SLOT_BYTES];
   int           step_count;
   rsp_word_type due_responses [$];
   plan_row_type plan [$];
   rsp_word_type seen_word;
   rsp_word_type due_word;
   int           words_sent  = 0;
   int           error_count = 0;

   bounded_message_fifo i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_data_byte  (req_data_byte),
      .req_end_of_msg (req_end_of_msg),
      .req_capacity   (req_capacity),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_msg_length (rsp_msg_length),
      .rsp_final_res  (rsp_final_res),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #10 clock = ~clock;

   // Works out the response words of one accepted request word and advances
   // the mirror; the words are left in step_words.
   task automatic compute_fifo_response(input logic rtype,
                                        input logic [bmf_pkg::BYTE_W-1:0] dbyte,
                                        input logic eom,
                                        input logic [bmf_pkg::LEN_W-1:0] cap);
      logic [bmf_pkg::LEN_W-1:0] len;
      bmf_pkg::status_type       st;
      rsp_word_type              w;
      step_count = 0;
      if (rtype == REQ_WRITE) begin
         // A byte is stored only while the message is still clean.
         if (open_reject == REJ_NONE) begin
            if (queued_msgs >= SLOTS) begin
               open_reject = REJ_FULL;
            end else if (open_bytes >= SLOT_BYTES) begin
               open_reject = REJ_LONG;
            end else begin
               byte_mirror[tail_slot][open_bytes] = dbyte;
               open_bytes = open_bytes + 1'b1;
            end
         end
         // At the close, a full queue outranks an over-long message.
         if (eom) begin
            len = open_bytes;
            if (open_reject == REJ_FULL || queued_msgs >= SLOTS) begin
               st  = bmf_pkg::ST_FULL;
               len = '0;
            end else if (open_reject == REJ_LONG || open_bytes > size_limit) begin
               st  = bmf_pkg::ST_LONG;
               len = '0;
            end else begin
               length_mirror[tail_slot] = open_bytes;
               tail_slot   = tail_slot + 1'b1;
               queued_msgs = queued_msgs + 1'b1;
               st          = bmf_pkg::ST_OK;
            end
            w             = '{st, 8'h00, len, 1'b1};
            step_words[0] = w;
            step_count    = 1;
            open_bytes    = '0;
            open_reject   = REJ_NONE;
         end
      end else if (queued_msgs == 0) begin
         w             = '{bmf_pkg::ST_EMPTY, 8'h00, 7'd0, 1'b1};
         step_words[0] = w;
         step_count    = 1;
      end else if (length_mirror[head_slot] > cap) begin
         w             = '{bmf_pkg::ST_SMALL, 8'h00, 7'd0, 1'b1};
         step_words[0] = w;
         step_count    = 1;
      end else begin
         // The head message streams out whole and leaves the queue.
         len = length_mirror[head_slot];
         for (int i = 0; i < len; i++) begin
            w = '{bmf_pkg::ST_OK, byte_mirror[head_slot][i], len, i == len - 1};
            step_words[i] = w;
         end
         step_count  = len;
         head_slot   = head_slot + 1'b1;
         queued_msgs = queued_msgs - 1'b1;
      end
   endtask

   // Presents one request word and holds it until the block takes it. Fields
   // that the request type ignores carry random values.
   task automatic issue_word(input logic rtype, input logic [bmf_pkg::BYTE_W-1:0] dbyte,
                             input logic eom, input logic [bmf_pkg::LEN_W-1:0] cap,
                             input logic typed, input bmf_pkg::status_type t_status,
                             input logic [bmf_pkg::LEN_W-1:0] t_len);
      rsp_word_type w;
      start          <= 1'b1;
      req_type       <= rtype;
      req_data_byte  <= (rtype == REQ_READ) ?
                        bmf_pkg::BYTE_W'($urandom_range(0, 255)) : dbyte;
      req_end_of_msg <= (rtype == REQ_READ) ? 1'($urandom_range(0, 1)) : eom;
      req_capacity   <= (rtype == REQ_WRITE) ?
                        bmf_pkg::LEN_W'($urandom_range(0, 127)) : cap;
      @(posedge clock);
      while (busy) @(posedge clock);
      compute_fifo_response(rtype, dbyte, eom, cap);
      if (typed) begin
         w = '{t_status, 8'h00, t_len, 1'b1};
         due_responses.push_back(w);
      end else begin
         for (int i = 0; i < step_count; i++) due_responses.push_back(step_words[i]);
      end
      words_sent++;
   endtask

   task automatic pause(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // The limit register is written only once the block has gone quiet.
   task automatic write_size_limit(input logic [bmf_pkg::LEN_W-1:0] value);
      start <= 1'b0;
      while (due_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      size_limit = value;
   endtask

   task automatic plan_row(input row_kind_type kind, input logic [7:0] value, input logic eom,
                           input logic [4:0] reps, input logic typed,
                           input bmf_pkg::status_type status,
                           input logic [bmf_pkg::LEN_W-1:0] msg_length);
      plan_row_type row;
      row = '{kind, value, eom, reps, typed, status, msg_length};
      plan.push_back(row);
   endtask

   // Mostly back-to-back words, some short gaps and the odd long one.
   function automatic int pick_gap(input logic burst);
      int roll;
      roll = $urandom_range(0, 9);
      if (burst || roll < 6) return 0;
      if (roll < 9) return $urandom_range(1, 3);
      return $urandom_range(5, 20);
   endfunction

   // Mostly short messages, a few long ones, rarely one that overruns a slot.
   function automatic int pick_msg_len();
      int roll;
      roll = $urandom_range(0, 49);
      if (roll < 35) return $urandom_range(1, 4);
      if (roll < 46) return $urandom_range(5, 16);
      if (roll < 49) return $urandom_range(17, SLOT_BYTES);
      return $urandom_range(SLOT_BYTES + 1, SLOT_BYTES + 6);
   endfunction

   // Capacities at or just below the head message's length, else random or large.
   function automatic logic [bmf_pkg::LEN_W-1:0] pick_capacity();
      logic [bmf_pkg::LEN_W-1:0] head_len;
      head_len = (queued_msgs != 0) ? length_mirror[head_slot] : 7'd1;
      case ($urandom_range(0, 9)) inside
         0, 1: begin
            return bmf_pkg::LEN_W'($urandom_range(0, 127));
         end
         2: begin
            return head_len - 1'b1;
         end
         3: begin
            return head_len;
         end
         default: begin
            return bmf_pkg::LEN_W'($urandom_range(64, 127));
         end
      endcase
   endfunction

   // One whole message, sometimes with a read slipped in between its words.
   task automatic send_message(input int n_bytes, input logic burst);
      for (int b = 0; b < n_bytes; b++) begin
         issue_word(REQ_WRITE, bmf_pkg::BYTE_W'($urandom_range(0, 255)), b == n_bytes - 1,
                    7'd0, 1'b0, bmf_pkg::ST_OK, 7'd0);
         pause(pick_gap(burst));
         if (b != n_bytes - 1 && $urandom_range(0, 9) == 0) begin
            issue_word(REQ_READ, 8'h00, 1'b0, pick_capacity(), 1'b0, bmf_pkg::ST_OK, 7'd0);
            pause(pick_gap(burst));
         end
      end
   endtask

   // Each response word is taken at the edge that ends its strobe cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe !== 1'b0) begin
         seen_word = '{bmf_pkg::status_type'(rsp_status), rsp_out_byte, rsp_msg_length,
                       rsp_final_res};
         if (due_responses.size() == 0) begin
            error_count++;
            $display("%0t: unexpected word, status %0d byte %02h length %0d final %0b",
                     $time, seen_word.status, seen_word.out_byte, seen_word.msg_length,
                     seen_word.final_res);
         end else begin
            due_word = due_responses.pop_front();
            if (seen_word !== due_word) begin
               error_count++;
               $display("%0t: status/byte/length/final expected %0d/%02h/%0d/%0b, got %0d/%02h/%0d/%0b",
                        $time, due_word.status, due_word.out_byte, due_word.msg_length,
                        due_word.final_res, seen_word.status, seen_word.out_byte,
                        seen_word.msg_length, seen_word.final_res);
            end
         end
      end
   end

   initial begin
      int                        stop_at;
      logic                      burst;
      logic                      fill;
      logic                      overran;
      logic [bmf_pkg::LEN_W-1:0] limit;

      // Empty queue after reset, then the smallest message through each read outcome.
      plan_row(ROW_READ,  8'd64,  1'b0, 5'd1,  1'b1, bmf_pkg::ST_EMPTY, 7'd0);
      plan_row(ROW_WRITE, 8'h00,  1'b1, 5'd1,  1'b1, bmf_pkg::ST_OK,    7'd1);
      plan_row(ROW_READ,  8'd0,   1'b0, 5'd1,  1'b1, bmf_pkg::ST_SMALL, 7'd0);
      plan_row(ROW_READ,  8'd1,   1'b0, 5'd1,  1'b0, bmf_pkg::ST_OK,    7'd0);
      // Two-byte message, and a read served while the next message is still open.
      plan_row(ROW_WRITE, 8'hFF,  1'b0, 5'd1,  1'b0, bmf_pkg::ST_OK,    7'd0);
      plan_row(ROW_WRITE, 8'hA5,  1'b1, 5'd1,  1'b1, bmf_pkg::ST_OK,    7'd2);
      plan_row(ROW_WRITE, 8'h5A,  1'b0, 5'd1,  1'b0, bmf_pkg::ST_OK,    7'd0);
      plan_row(ROW_READ,  8'd127, 1'b0, 5'd1,  1'b0, bmf_pkg::ST_OK,    7'd0);
      plan_row(ROW_WRITE, 8'h3C,  1'b1, 5'd1,  1'b1, bmf_pkg::ST_OK,    7'd2);
      plan_row(ROW_READ,  8'd2,   1'b0, 5'd1,  1'b0, bmf_pkg::ST_OK,    7'd0);
      // A limit of zero rejects even one byte; a limit of one rejects two.
      plan_row(ROW_CSR,   8'd0,   1'b0, 5'd1,  1'b0, bmf_pkg::ST_OK,    7'd0);
      plan_row(ROW_WRITE, 8'h81,  1'b1, 5'd1,  1'b1, bmf_pkg::ST_LONG,  7'd0);
      plan_row(ROW_CSR,   8'd1,   1'b0, 5'd1,  1'b0, bmf_pkg::ST_OK,    7'd0);
      plan_row(ROW_WRITE, 8'h7E,  1'b0, 5'd1,  1'b0, bmf_pkg::ST_OK,    7'd0);
      plan_row(ROW_WRITE, 8'h18,  1'b1, 5'd1,  1'b1, bmf_pkg::ST_LONG,  7'd0);
      // Limit above the slot size; every slot filled, then one message too many.
      plan_row(ROW_CSR,   8'd127, 1'b0, 5'd1,  1'b0, bmf_pkg::ST_OK,    7'd0);
      plan_row(ROW_WRITE, 8'h42,  1'b1, 5'd16, 1'b1, bmf_pkg::ST_OK,    7'd1);
      plan_row(ROW_WRITE, 8'h11,  1'b1, 5'd1,  1'b1, bmf_pkg::ST_FULL,  7'd0);
      // A message begun on a full queue stays rejected though a read frees a slot.
      plan_row(ROW_WRITE, 8'h22,  1'b0, 5'd1,  1'b0, bmf_pkg::ST_OK,    7'd0);
      plan_row(ROW_READ,  8'd64,  1'b0, 5'd1,  1'b0, bmf_pkg::ST_OK,    7'd0);
      plan_row(ROW_WRITE, 8'h33,  1'b1, 5'd1,  1'b1, bmf_pkg::ST_FULL,  7'd0);
      plan_row(ROW_WRITE, 8'h44,  1'b1, 5'd1,  1'b1, bmf_pkg::ST_OK,    7'd1);
      plan_row(ROW_CSR,   8'd64,  1'b0, 5'd1,  1'b0, bmf_pkg::ST_OK,    7'd0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      foreach (plan[r]) begin
         if (plan[r].kind == ROW_CSR) begin
            write_size_limit(plan[r].value[bmf_pkg::LEN_W-1:0]);
         end else begin
            repeat (plan[r].reps) begin
               issue_word((plan[r].kind == ROW_READ) ? REQ_READ : REQ_WRITE, plan[r].value,
                          plan[r].eom, plan[r].value[bmf_pkg::LEN_W-1:0], plan[r].typed,
                          plan[r].status, plan[r].msg_length);
               pause(pick_gap(1'b0));
            end
         end
      end

      // Random traffic in phases, each with its own limit and its own bias
      // towards filling or draining the queue.
      stop_at = words_sent + 200;
      overran = 1'b0;
      while (words_sent < stop_at) begin
         case ($urandom_range(0, 5))
            0: begin
               limit = bmf_pkg::LEN_LIMIT_RST;
            end
            1: begin
               limit = 7'd1;
            end
            2: begin
               limit = 7'd0;
            end
            3: begin
               limit = 7'd127;
            end
            4: begin
               limit = bmf_pkg::LEN_W'($urandom_range(1, SLOT_BYTES));
            end
            default: begin
               limit = bmf_pkg::LEN_W'($urandom_range(0, 127));
            end
         endcase
         write_size_limit(limit);
         burst = ($urandom_range(0, 3) == 0);
         fill  = 1'($urandom_range(0, 1));
         for (int a = 0; a < 16 && words_sent < stop_at; a++) begin
            // One message that overruns its slot, as soon as there is room for it.
            if (!overran && queued_msgs < SLOTS) begin
               send_message(SLOT_BYTES + 2, burst);
               overran = 1'b1;
            end else if ($urandom_range(0, 9) < (fill ? 8 : 4)) begin
               send_message(pick_msg_len(), burst);
            end else begin
               issue_word(REQ_READ, 8'h00, 1'b0, pick_capacity(), 1'b0, bmf_pkg::ST_OK,
                          7'd0);
               pause(pick_gap(burst));
            end
         end
      end

      // Drain the outstanding responses, then allow for stray words.
      start <= 1'b0;
      while (due_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog for a stuck handshake or a response that never comes.
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
